@@ rtl/core/needle_window_solenoid_driver_macros.svh @@
// ----------------------------------------------------------------------------
// Needle window solenoid driver assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NEEDLE_WINDOW_SOLENOID_DRIVER_MACROS_SVH
`define NEEDLE_WINDOW_SOLENOID_DRIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NWSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NWSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/nwsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Needle window solenoid driver package
// Command codes, state encoding and fixed field widths.
// ----------------------------------------------------------------------------
package nwsd_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned DRIVE_W  = 16;

  // Command codes.
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_TURN  = 2'd1;
  localparam cmd_t CMD_MOVE  = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_REDUCE = 6'b000100,
    ST_ROTATE = 6'b001000,
    ST_WALK   = 6'b010000,
    ST_DRAIN  = 6'b100000
  } state_t;

endpackage

@@ rtl/core/nwsd_ram.sv @@
// ----------------------------------------------------------------------------
// Needle window solenoid driver RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module nwsd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 200
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/needle_window_solenoid_driver.sv @@
// ----------------------------------------------------------------------------
// Needle window solenoid driver
// Pattern store, half-shift mode and the needle window walk for one move.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A pattern write
// and a turnmark leave busy low, so another transaction may follow at once.
// A move raises busy through the states REDUCE, ROTATE, WALK and DRAIN: the
// position reduction finds the start solenoid with one restoring step per
// cycle, one per quotient bit (QB, 7 at the defaults); ROTATE applies the
// half-shift rotation; the window of SOLENOIDS+1 needles is read one needle
// per cycle through the single read port of the pattern memory; and DRAIN
// lets the last read land. The drive vector then stands on solenoid_drive
// for one cycle with done high, the first cycle with busy low again; the
// receiver must take it in that cycle. After reset the pattern memory is
// cleared one entry per cycle, with busy high.
// ----------------------------------------------------------------------------
`include "needle_window_solenoid_driver_macros.svh"

module needle_window_solenoid_driver #(
  parameter int SOLENOIDS    = 16,
  parameter int NEEDLES      = 200,
  parameter int CARRIAGE_GAP = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  nwsd_pkg::cmd_t                       cmd,
  input  logic [nwsd_pkg::IDX_W-1:0]           needle_index,
  input  logic                                 bit_value,
  input  logic                                 l_carriage,
  input  logic                                 at_left_side,
  input  logic                                 bp_level,
  input  logic signed [nwsd_pkg::POS_W-1:0]    carriage_position,
  input  logic                                 moving_left,
  output logic                                 done,
  output logic [nwsd_pkg::DRIVE_W-1:0]         solenoid_drive
);

  import nwsd_pkg::*;

  // Only needles reachable by the 8-bit index are ever stored.
  localparam int DEPTH  = (NEEDLES < 256) ? NEEDLES : 256;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(SOLENOIDS);
  localparam int CW     = $clog2(SOLENOIDS + 1);
  localparam int HALF   = SOLENOIDS / 2;
  // Window bounds and needle counter width.
  localparam int LO_NEG = 512 + CARRIAGE_GAP + SOLENOIDS;
  localparam int HI_POS = 511 + CARRIAGE_GAP + SOLENOIDS + 1;
  localparam int MAG_A  = (LO_NEG > HI_POS) ? LO_NEG : HI_POS;
  localparam int MAG    = (MAG_A > NEEDLES) ? MAG_A : NEEDLES;
  localparam int NW     = $clog2(MAG + 1) + 1;
  // Bias that makes every window start non-negative, a multiple of SOLENOIDS.
  localparam int BIAS   = SOLENOIDS * ((LO_NEG + SOLENOIDS - 1) / SOLENOIDS);
  localparam int RMAX   = 511 + CARRIAGE_GAP + BIAS;
  localparam int RW     = $clog2(RMAX + 1);
  localparam int QB     = $clog2(RMAX / SOLENOIDS + 1);
  localparam int XW     = ((NW > RW) ? NW : RW) + 1;

  localparam logic [RW-1:0]        DIV_INIT = RW'(SOLENOIDS * (2 ** (QB - 1)));
  localparam logic [RW-1:0]        DIV_LAST = RW'(SOLENOIDS);
  localparam logic signed [NW-1:0] GAP_N    = NW'(CARRIAGE_GAP);
  localparam logic signed [NW-1:0] SOL_N    = NW'(SOLENOIDS);
  localparam logic signed [NW-1:0] DEPTH_N  = NW'(DEPTH);
  localparam logic [SW-1:0]        SOL_MAX  = SW'(SOLENOIDS - 1);
  localparam logic [CW-1:0]        CNT_LAST = CW'(SOLENOIDS);

  state_t                state;
  logic                  accept;
  logic                  half_shift_mode;
  logic [AW-1:0]         clr;
  logic signed [NW-1:0]  pos_ext;
  logic signed [NW-1:0]  lo;
  logic signed [NW-1:0]  needle;
  logic [RW-1:0]         rem;
  logic [RW-1:0]         div;
  logic [SW:0]           rot_sum;
  logic [SW-1:0]         sidx;
  logic [CW-1:0]         cnt;
  logic                  in_bed;
  logic                  pend_valid;
  logic [SW-1:0]         pend_sidx;
  logic                  pend_in_bed;
  logic [SOLENOIDS-1:0]  sol;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  ram_wdata;
  logic                  ram_rdata;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Window start: behind the carriage, on the side it moves away from.
  assign pos_ext = NW'(carriage_position);
  assign lo      = moving_left ? (pos_ext + GAP_N) : (pos_ext - GAP_N - SOL_N);

  // Needle inside the stored part of the bed.
  assign in_bed  = !needle[NW-1] && (needle < DEPTH_N);

  // Half-shift rotation of the reduced start solenoid.
  assign rot_sum = {1'b0, rem[SW-1:0]} + (half_shift_mode ? (SW+1)'(HALF) : '0);

  // Pattern memory write: clearing pass or a pattern write transaction.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr;
    ram_wdata = 1'b0;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && (cmd == CMD_WRITE) && (32'(needle_index) < NEEDLES)) begin
      ram_we    = 1'b1;
      ram_waddr = needle_index[AW-1:0];
      ram_wdata = bit_value;
    end
  end

  nwsd_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_pattern (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (needle[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer for the clearing pass and the move walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr             <= '0;
      half_shift_mode <= 1'b0;
      pend_valid      <= 1'b0;
    end else begin
      pend_valid <= (state == ST_WALK);
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (cmd == CMD_TURN)) begin
            half_shift_mode <= l_carriage ? !bp_level :
                               (at_left_side ? bp_level : !bp_level);
          end
          if (accept && (cmd == CMD_MOVE)) begin
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (div == DIV_LAST) begin
            state <= ST_ROTATE;
          end
        end
        ST_ROTATE: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (cnt == CNT_LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: restoring reduction, then one needle per cycle.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept && (cmd == CMD_MOVE)) begin
      needle <= lo;
      rem    <= RW'(XW'(lo) + XW'(BIAS));
      div    <= DIV_INIT;
    end
    if (state == ST_REDUCE) begin
      if (rem >= div) begin
        rem <= rem - div;
      end
      div <= div >> 1;
    end
    if (state == ST_ROTATE) begin
      sidx <= (rot_sum >= (SW+1)'(SOLENOIDS)) ? SW'(rot_sum - (SW+1)'(SOLENOIDS))
                                              : SW'(rot_sum);
      cnt  <= '0;
    end
    if (state == ST_WALK) begin
      pend_sidx   <= sidx;
      pend_in_bed <= in_bed;
      needle      <= needle + NW'(1);
      sidx        <= (sidx == SOL_MAX) ? '0 : sidx + SW'(1);
      cnt         <= cnt + CW'(1);
    end
    // The later needle overwrites where two share a solenoid.
    if (pend_valid) begin
      sol[pend_sidx] <= pend_in_bed & ram_rdata;
    end
  end

  // The result stands for the cycle after the last needle lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DRAIN);
    end
  end

  // Solenoids beyond the output width are not visible.
  generate
    if (SOLENOIDS >= DRIVE_W) begin : g_wide
      assign solenoid_drive = sol[DRIVE_W-1:0];
    end else begin : g_narrow
      assign solenoid_drive = DRIVE_W'(sol);
    end
  endgenerate

  // Checks on the sequencer and the walk counters.
  `NWSD_ASSERT_NEXT(a_move_starts, clk, rst, accept && (cmd == CMD_MOVE), state == ST_REDUCE, "move did not start reduction")
  `NWSD_ASSERT_NOW(a_rem_reduced, clk, rst, state == ST_ROTATE, rem < RW'(SOLENOIDS), "start solenoid not reduced")
  `NWSD_ASSERT_NOW(a_sidx_range, clk, rst, state == ST_WALK, (32'(sidx) < SOLENOIDS) && (cnt <= CNT_LAST), "walk counters out of range")
  `NWSD_ASSERT_NEXT(a_done_after_drain, clk, rst, state == ST_DRAIN, done && (state == ST_IDLE), "result not delivered after walk")

endmodule
